>>> hw/rtl/rpsa_pkg.sv
// Shared constants, command codes and handshake structs for the region probe
// slot allocator. Depends on nothing; used by rpsa_mod_unit and the top level.
`timescale 1ns / 1ps

package rpsa_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES  = 4096;
  localparam int unsigned REGION_ENTRIES = 64;
  localparam int unsigned BLOCK_BITS     = 32;

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned REG_W  = $clog2(REGION_ENTRIES);
  localparam int unsigned ROWS   = TABLE_ENTRIES / REGION_ENTRIES;
  localparam int unsigned ROW_W  = IDX_W - REG_W;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned FP_W   = 64;
  localparam int unsigned BLK_W  = 32;
  localparam int unsigned CMD_W  = 2;

  // Remainder unit: bits of the fingerprint retired per cycle
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_STEPS = FP_W / DIV_BITS;
  localparam int unsigned DIV_CW    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Region search: bits of the rotated free map inspected per cycle
  localparam int unsigned SEARCH_W     = (REGION_ENTRIES < 8) ? REGION_ENTRIES : 8;
  localparam int unsigned SEARCH_STEPS = REGION_ENTRIES / SEARCH_W;
  localparam int unsigned SEARCH_CW    = (SEARCH_STEPS > 1) ? $clog2(SEARCH_STEPS) : 1;
  localparam int unsigned SEARCH_PW    = (SEARCH_W > 1) ? $clog2(SEARCH_W) : 1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // Register map
  localparam int unsigned     APB_AW       = 3;
  localparam logic [APB_AW-1:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [CNT_W-1:0]  ENTRY_COUNT_RST = CNT_W'(TABLE_ENTRIES);

  // Remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [FP_W-1:0]  dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

endpackage

>>> hw/rtl/rpsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rpsa_mod_unit.sv
// Iterative remainder unit: fingerprint modulo entry count, DIV_BITS bits
// per cycle, most significant first. Depends on rpsa_pkg.
`timescale 1ns / 1ps

module rpsa_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpsa_pkg::mod_req_t req_i,
  output rpsa_pkg::mod_rsp_t rsp_o
);

  import rpsa_pkg::*;

  logic              busy_q, busy_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [FP_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  rem_step;
  logic [IDX_W:0]    trial;
  logic              last;

  // DIV_BITS restoring steps on the narrow partial remainder
  always_comb begin
    rem_step = rem_q;
    trial    = '0;
    for (int i = 0; i < int'(DIV_BITS); i++) begin
      trial = {rem_step, dvd_q[FP_W-1-i]};
      if (trial >= (IDX_W+1)'(div_q)) begin
        trial = trial - (IDX_W+1)'(div_q);
      end
      rem_step = trial[IDX_W-1:0];
    end
  end

  assign last = (cnt_q == DIV_CW'(DIV_STEPS - 1));

  // Sequencing
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_step;
      dvd_d = dvd_q << DIV_BITS;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = busy_q && last;
  assign rsp_o.rem  = rem_step;

endmodule

>>> hw/rtl/region_probe_slot_allocator_core.sv
// Top level of the region probe slot allocator: stream ports, APB register,
// occupancy bitmap RAM and command sequencer. Depends on rpsa_pkg, rpsa_ram
// and rpsa_mod_unit.
//
// Usage: one request per beat on the s_axis side (tuser = command, tdata =
// fingerprint, entry_index, block_number); exactly one result per request on
// the m_axis side (tdata = slot_index, tuser = region_exhausted, misuse).
// Requests are handled one at a time. After the accept, alloc passes the
// remainder unit (8 bits of the fingerprint per cycle), the bitmap row read,
// the region search (8 entries per cycle) and the hand off to the result
// register; write and free pass the row read, the modify and write back and
// the hand off, an unknown command only the hand off. The next request is
// taken the cycle after the previous one has reached the output register, so
// a stalled receiver holds at most one finished result while the next
// request is already being worked on; a second result waits inside. The
// occupancy is one bit per entry, one RAM row per region; a row valid flag
// per row, cleared at reset, makes the whole table read free right after
// reset with no clearing pass. entry_count resets to 4096; the user writes
// it through the APB port only while the block is idle; it is not enforced.
`timescale 1ns / 1ps

module region_probe_slot_allocator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] fingerprint, [75:64] entry_index, [107:76] block_number, [111:108] zero
  input  logic [111:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser,
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [11:0] slot_index, [15:12] zero
  output logic [15:0]  m_axis_tdata,
  // [0] region_exhausted, [1] misuse
  output logic [1:0]   m_axis_tuser
);

  import rpsa_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_SEARCH = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  // Request fields
  logic [CMD_W-1:0] in_cmd;
  logic [FP_W-1:0]  in_fp;
  logic [IDX_W-1:0] in_idx;
  logic [BLK_W-1:0] in_blk;
  logic             in_acc;

  assign in_cmd = s_axis_tuser;
  assign in_fp  = s_axis_tdata[FP_W-1:0];
  assign in_idx = s_axis_tdata[FP_W +: IDX_W];
  assign in_blk = s_axis_tdata[FP_W+IDX_W +: BLK_W];

  // Register port
  logic [CNT_W-1:0] entry_count_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT[2]);
  assign prdata = (paddr[2] == REG_ENTRY_COUNT[2]) ? {{(32-CNT_W){1'b0}}, entry_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= ENTRY_COUNT_RST;
    end else if (cfg_wr) begin
      entry_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Zero or oversized count means the full table
  logic [CNT_W-1:0] eff_count;
  assign eff_count = (entry_count_q == '0 || entry_count_q > CNT_W'(TABLE_ENTRIES))
                   ? CNT_W'(TABLE_ENTRIES) : entry_count_q;

  // Sequencer state
  logic [2:0]           state_q, state_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic                 blk_zero_q, blk_zero_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [REG_W-1:0]     bit_q, bit_d;
  logic [REGION_ENTRIES-1:0] rot_q, rot_d;
  logic [SEARCH_CW-1:0] grp_q, grp_d;
  logic [IDX_W-1:0]     res_slot_q, res_slot_d;
  logic                 res_full_q, res_full_d;
  logic                 res_bad_q, res_bad_d;
  logic [ROWS-1:0]      row_vld_q, row_vld_d;

  // Output register
  logic             out_vld_q, out_vld_d;
  logic [IDX_W-1:0] out_slot_q, out_slot_d;
  logic             out_full_q, out_full_d;
  logic             out_bad_q, out_bad_d;

  // Remainder unit
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  rpsa_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Occupancy bitmap, one region per row
  logic                      ram_we, ram_re;
  logic [REGION_ENTRIES-1:0] ram_wdata, ram_rdata;

  rpsa_ram #(
    .WIDTH (REGION_ENTRIES),
    .DEPTH (ROWS)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (row_q),
    .rdata_o (ram_rdata)
  );

  // Row contents as seen after read; unwritten rows are all free
  logic [REGION_ENTRIES-1:0]   row_occ, free_map;
  logic [2*REGION_ENTRIES-1:0] free_dbl;
  assign row_occ  = row_vld_q[row_q] ? ram_rdata : '0;
  assign free_map = ~row_occ;
  assign free_dbl = {free_map, free_map} >> bit_q;

  // Search window: one group of the rotated free map
  logic [SEARCH_W-1:0]  grp_bits;
  logic [SEARCH_PW-1:0] grp_pos;
  logic [REG_W-1:0]     hit_off;
  assign grp_bits = rot_q[grp_q*SEARCH_W +: SEARCH_W];

  always_comb begin
    grp_pos = '0;
    for (int i = SEARCH_W - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        grp_pos = SEARCH_PW'(i);
      end
    end
  end

  assign hit_off = REG_W'(REG_W'(grp_q) * REG_W'(SEARCH_W) + REG_W'(grp_pos));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Command sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    blk_zero_d = blk_zero_q;
    row_d      = row_q;
    bit_d      = bit_q;
    rot_d      = rot_q;
    grp_d      = grp_q;
    res_slot_d = res_slot_q;
    res_full_d = res_full_q;
    res_bad_d  = res_bad_q;
    row_vld_d  = row_vld_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_slot_d = out_slot_q;
    out_full_d = out_full_q;
    out_bad_d  = out_bad_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = row_occ;

    mod_req.start    = 1'b0;
    mod_req.dividend = in_fp;
    mod_req.divisor  = eff_count;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d      = in_cmd;
          blk_zero_d = (in_blk[BLOCK_BITS-1:0] == '0);
          row_d      = in_idx[IDX_W-1:REG_W];
          bit_d      = in_idx[REG_W-1:0];
          res_slot_d = '0;
          res_full_d = 1'b0;
          res_bad_d  = 1'b0;
          if (in_cmd == CMD_ALLOC) begin
            mod_req.start = 1'b1;
            state_d       = ST_DIV;
          end else if (in_cmd == CMD_WRITE || in_cmd == CMD_FREE) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (mod_rsp.done) begin
          row_d   = mod_rsp.rem[IDX_W-1:REG_W];
          bit_d   = mod_rsp.rem[REG_W-1:0];
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (cmd_q == CMD_ALLOC) begin
          rot_d   = free_dbl[REGION_ENTRIES-1:0];
          grp_d   = '0;
          state_d = ST_SEARCH;
        end else if (cmd_q == CMD_WRITE) begin
          if (row_occ[bit_q] || blk_zero_q) begin
            res_bad_d = 1'b1;
          end else begin
            ram_we           = 1'b1;
            ram_wdata[bit_q] = 1'b1;
            row_vld_d[row_q] = 1'b1;
          end
          state_d = ST_OUT;
        end else begin
          ram_we           = 1'b1;
          ram_wdata[bit_q] = 1'b0;
          row_vld_d[row_q] = 1'b1;
          state_d          = ST_OUT;
        end
      end
      ST_SEARCH: begin
        if (grp_bits != '0) begin
          res_slot_d = {row_q, REG_W'(bit_q + hit_off)};
          state_d    = ST_OUT;
        end else if (grp_q == SEARCH_CW'(SEARCH_STEPS - 1)) begin
          res_full_d = 1'b1;
          state_d    = ST_OUT;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_slot_d = res_slot_q;
          out_full_d = res_full_q;
          out_bad_d  = res_bad_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    blk_zero_q <= blk_zero_d;
    row_q      <= row_d;
    bit_q      <= bit_d;
    rot_q      <= rot_d;
    grp_q      <= grp_d;
    res_slot_q <= res_slot_d;
    res_full_q <= res_full_d;
    res_bad_q  <= res_bad_d;
    out_slot_q <= out_slot_d;
    out_full_q <= out_full_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(16-IDX_W){1'b0}}, out_slot_q};
  assign m_axis_tuser  = {out_bad_q, out_full_q};

`ifndef SYNTHESIS
  // The bitmap is only written in the modify step of a write or free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_LOAD && cmd_q != CMD_ALLOC))
    else $error("bitmap write outside read-modify-write");

  // A full region reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("full region with nonzero slot");

  // Full region and misuse never come together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("full region and misuse both set");

  // One request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second request taken while busy");

  // Remainder result only arrives while waiting for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == ST_DIV))
    else $error("remainder done outside divide phase");
`endif

endmodule

>>> tb/region_probe_slot_allocator_core_tb.sv
// Testbench for region_probe_slot_allocator_core: streams alloc, write, free and unused
// requests, predicts every result from a private copy of the occupancy table and checks it.
// Depends on rpsa_pkg and the core RTL only.
`timescale 1ns / 1ps

module region_probe_slot_allocator_core_tb;
  import rpsa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 30;
  localparam int PHASE_ITEMS    = 145;
  localparam int NUM_PHASES     = 10;

  // One expected result per request
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             full;
    logic             misuse;
  } slot_result_t;

  // Occupancy table predictor plus the queue of results still owed by the core
  class SlotTableModel;
    logic [BLK_W-1:0] blocks [TABLE_ENTRIES];
    logic [CNT_W-1:0] entry_count;
    slot_result_t     owed_results[$];
    int mismatches, n_alloc, n_write, n_free, n_unused, n_full, n_misuse;

    function void clear();
      foreach (blocks[i]) blocks[i] = '0;
      entry_count = ENTRY_COUNT_RST;
      owed_results.delete();
    endfunction

    // zero or oversized counts fall back to the full table
    function int unsigned divisor();
      if (entry_count == 0 || entry_count > TABLE_ENTRIES) return TABLE_ENTRIES;
      return entry_count;
    endfunction

    // first free entry of the home region, scanning from the home slot and wrapping
    function slot_result_t search_region(logic [FP_W-1:0] fp);
      slot_result_t res;
      logic [FP_W-1:0] home;
      int unsigned base, start, off;
      res = '0;
      res.full = 1'b1;
      home = fp % FP_W'(divisor());
      base = int'(home) - int'(home) % REGION_ENTRIES;
      start = int'(home) % REGION_ENTRIES;
      for (int k = 0; k < REGION_ENTRIES && res.full; k++) begin
        off = (start + k) % REGION_ENTRIES;
        if (blocks[(base + off) % TABLE_ENTRIES] == '0) begin
          res.slot = IDX_W'(base + off);
          res.full = 1'b0;
        end
      end
      if (res.full) res.slot = '0;
      return res;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [FP_W-1:0] fp,
                               logic [IDX_W-1:0] idx, logic [BLK_W-1:0] blk);
      slot_result_t res;
      res = '0;
      case (cmd)
        CMD_ALLOC: begin
          res = search_region(fp);
          n_alloc++;
          if (res.full) n_full++;
        end
        CMD_WRITE: begin
          n_write++;
          if (blocks[idx] != '0 || blk == '0) begin
            res.misuse = 1'b1;
            n_misuse++;
          end else begin
            blocks[idx] = blk;
          end
        end
        CMD_FREE: begin
          n_free++;
          blocks[idx] = '0;
        end
        default: n_unused++;
      endcase
      owed_results.push_back(res);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [IDX_W-1:0] slot, logic full, logic misuse);
      slot_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: result with none pending, expected nothing, got slot %0h full %b misuse %b",
                   $time, slot, full, misuse);
        return;
      end
      want = owed_results.pop_front();
      if (slot !== want.slot) report("slot_index", want.slot, slot);
      if (full !== want.full) report("region_exhausted", want.full, full);
      if (misuse !== want.misuse) report("misuse", want.misuse, misuse);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [63:0] fingerprint, [75:64] entry_index, [107:76] block_number, [111:108] zero
  logic [111:0] s_axis_tdata = '0;
  // [1:0] command
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [11:0] slot_index, [15:12] zero
  logic [15:0]  m_axis_tdata;
  // [0] region_exhausted, [1] misuse
  logic [1:0]   m_axis_tuser;

  SlotTableModel table_model;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int requests_sent = 0;
  int hot_lo = 0;
  int hot_hi = 0;

  region_probe_slot_allocator_core i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check accepted results, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        table_model.check_result(m_axis_tdata[IDX_W-1:0], m_axis_tuser[0], m_axis_tuser[1]);
      if (long_hold_req) begin
        hold_left = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no handshake on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still pending", $time,
               table_model.owed_results.size());
      $display("region_probe_slot_allocator_core: mismatch");
      $finish;
    end
  end

  // Leaves tvalid high after the accept so back-to-back requests need one assignment
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [FP_W-1:0] fp,
                              input logic [IDX_W-1:0] idx, input logic [BLK_W-1:0] blk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0, blk, idx, fp};
    do @(posedge clk_i); while (!s_axis_tready);
    table_model.note_request(cmd, fp, idx, blk);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (table_model.owed_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= REG_ENTRY_COUNT;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_entry_count(input logic [31:0] value);
    logic [31:0] readback;
    apb_access(1'b1, value, readback);
    apb_access(1'b0, '0, readback);
    table_model.entry_count = value[CNT_W-1:0];
    if (readback !== 32'(value[CNT_W-1:0]))
      table_model.report("entry_count readback", 32'(value[CNT_W-1:0]), readback);
  endtask

  function automatic logic [FP_W-1:0] random_fingerprint();
    return {$urandom, $urandom};
  endfunction

  // fingerprint whose home slot lands in the current hot region
  function automatic logic [FP_W-1:0] hot_fingerprint();
    logic [FP_W-1:0] k;
    logic [FP_W-1:0] home;
    k = {13'b0, 19'($urandom_range(0, 19'h7FFFF)), 32'($urandom)};
    home = FP_W'($urandom_range(hot_lo, hot_hi));
    return home + k * FP_W'(table_model.divisor());
  endfunction

  function automatic logic [IDX_W-1:0] hot_entry();
    return IDX_W'(hot_lo - hot_lo % REGION_ENTRIES + $urandom_range(0, REGION_ENTRIES - 1));
  endfunction

  // Alloc followed by a write that claims the slot it returned
  task automatic alloc_and_claim(input logic [FP_W-1:0] fp);
    slot_result_t found;
    send_request(CMD_ALLOC, fp, IDX_W'($urandom), 32'($urandom));
    found = table_model.search_region(fp);
    send_request(CMD_WRITE, random_fingerprint(), found.full ? hot_entry() : found.slot,
                 32'($urandom_range(1, 32'hFFFF_FFFF)));
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      alloc_and_claim(($urandom_range(99) < 80) ? hot_fingerprint() : random_fingerprint());
    else if (r < 57)
      send_request(CMD_FREE, random_fingerprint(), hot_entry(), 32'($urandom));
    else if (r < 67)
      send_request(CMD_ALLOC, ($urandom_range(99) < 70) ? hot_fingerprint()
                   : random_fingerprint(), IDX_W'($urandom), 32'($urandom));
    else if (r < 79)
      send_request(CMD_WRITE, random_fingerprint(), IDX_W'($urandom), 32'($urandom));
    else if (r < 85)
      send_request(CMD_WRITE, random_fingerprint(), IDX_W'($urandom), '0);
    else if (r < 93)
      send_request(CMD_FREE, random_fingerprint(), IDX_W'($urandom), 32'($urandom));
    else
      send_request(CMD_UNUSED, random_fingerprint(), IDX_W'($urandom), 32'($urandom));
  endtask

  initial begin
    logic [31:0] count_settings [NUM_PHASES];
    int phase_start;
    int eff;
    bit paused;
    count_settings = '{32'd1, 32'd4096, 32'd0, 32'hFFFF_FFFF, 32'd37, 32'd130, 32'd4097,
                       32'd64, 32'd4095, 32'd2};
    table_model = new();
    table_model.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, probe wrap, misuse, double free, unused code
    send_request(CMD_ALLOC, '0, '0, '0);
    send_request(CMD_ALLOC, '1, '1, '1);
    send_request(CMD_WRITE, '1, '0, '1);
    send_request(CMD_WRITE, '0, '1, 32'd1);
    send_request(CMD_WRITE, '0, '0, 32'd5);
    send_request(CMD_WRITE, '1, 12'd100, '0);
    send_request(CMD_ALLOC, '0, '0, '0);
    send_request(CMD_ALLOC, 64'd4095, '0, '0);
    send_request(CMD_ALLOC, 64'd4159, '0, '0);
    send_request(CMD_FREE, '0, '0, '0);
    send_request(CMD_FREE, '1, '0, '1);
    send_request(CMD_UNUSED, '1, '1, '1);
    send_request(CMD_ALLOC, '0, '0, '0);
    send_request(CMD_WRITE, 64'h8000_0000_0000_0000, 12'h800, 32'h8000_0000);
    send_request(CMD_FREE, '0, '1, '0);
    send_request(CMD_ALLOC, 64'd4095, '0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      set_entry_count(count_settings[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
        default: begin src_idle_pct = 38; sink_stall_pct = 38; end
      endcase
      eff = table_model.divisor();
      hot_lo = $urandom_range(0, (eff - 1) / REGION_ENTRIES) * REGION_ENTRIES;
      hot_hi = (hot_lo + REGION_ENTRIES - 1 < eff - 1) ? hot_lo + REGION_ENTRIES - 1 : eff - 1;
      phase_start = requests_sent;
      paused = 1'b0;
      // receiver goes quiet while requests keep coming
      if (p == 0) long_hold_req = 1'b1;
      // small counts: fill the home region until it reports full
      if (eff < REGION_ENTRIES)
        repeat (REGION_ENTRIES + 2) alloc_and_claim(hot_fingerprint());
      while (requests_sent - phase_start < PHASE_ITEMS) begin
        if (p == 3 && !paused && requests_sent - phase_start >= PHASE_ITEMS / 2) begin
          wait_results_done();
          paused = 1'b1;
        end
        random_request();
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d alloc (%0d region full), %0d write (%0d misuse),",
             requests_sent + table_model.n_unused, table_model.n_alloc, table_model.n_full,
             table_model.n_write, table_model.n_misuse);
    $display("%0d free, %0d unused-code, over %0d entry_count settings and four idle mixes.",
             table_model.n_free, table_model.n_unused, NUM_PHASES);
    if (table_model.mismatches == 0) begin
      $display("region_probe_slot_allocator_core: match");
    end else begin
      $display("region_probe_slot_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
